### sv/kscl_pkg.sv
// ---------------------------------------------------------------------------
// kscl_pkg
// Shared widths, codes and reset values for the keypad scan code lock.
// ---------------------------------------------------------------------------
`default_nettype none

package kscl_pkg;

    localparam int NUM_DIGITS   = 4;
    localparam int DIGIT_W      = 4;
    localparam int COL_W        = 3;
    localparam int ROW_W        = 4;
    localparam int COUNT_W      = 3;
    localparam int PW_W         = NUM_DIGITS * DIGIT_W;
    localparam int CFG_IDX_W    = 8;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 24;

    localparam logic [DIGIT_W-1:0] EMPTY_DIGIT = 4'd10;
    localparam logic [COUNT_W-1:0] FULL_COUNT  = 3'd4;
    localparam logic [COUNT_W-1:0] MAX_FAILS   = 3'd4;

    // Input word kind (tuser)
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Verdict codes
    localparam logic [1:0] VERDICT_NONE   = 2'd0;
    localparam logic [1:0] VERDICT_ACCEPT = 2'd1;
    localparam logic [1:0] VERDICT_REJECT = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PW_FIRST  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PW_SECOND = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PW_THIRD  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PW_FOURTH = 8'd3;

    localparam logic [PW_W-1:0] PW_FIRST_RST  = 16'h1234;
    localparam logic [PW_W-1:0] PW_SECOND_RST = 16'h2345;
    localparam logic [PW_W-1:0] PW_THIRD_RST  = 16'h3456;
    localparam logic [PW_W-1:0] PW_FOURTH_RST = 16'h4567;

    // Column drive phases (active low, bit0 right .. bit2 left)
    localparam logic [COL_W-1:0] COL_RESET  = 3'b000;
    localparam logic [COL_W-1:0] COL_LEFT   = 3'b011;
    localparam logic [COL_W-1:0] COL_MIDDLE = 3'b101;
    localparam logic [COL_W-1:0] COL_RIGHT  = 3'b110;

    typedef struct packed {
        logic               warning_on;
        logic [COUNT_W-1:0] failed_count;
        logic [1:0]         verdict;
        logic [COUNT_W-1:0] digits_held;
        logic               clear_pressed;
        logic [DIGIT_W-1:0] key_digit;
        logic               key_entered;
        logic [COL_W-1:0]   column_drive;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage : kscl_pkg

`default_nettype wire

### sv/keypad_scan_code_lock_core.sv
// ---------------------------------------------------------------------------
// keypad_scan_code_lock_core
// 3x4 matrix keypad scanner with a four-digit code lock.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*): one word per scan event. tuser = op (0 column tick,
//   1 row sample), tdata[3:0] = active-low rows. Every word gives exactly
//   one result word on the master stream (m_*).
//   Config channel (i_cfg_*): writes password registers 0..3 (four BCD
//   digits, first digit in the top nibble). Writes to other indexes are
//   dropped. o_cfg_ready is always high.
//   An accepted word's result is registered in the result register, or in the skid
//   register while that one waits. Throughput: one word per cycle while s_tready is
//   high, set by the single decode/compare pass between handshake and result register.
//   Stall: a two-entry output (result register plus skid register) keeps the
//   input open for one more word while the result waits; s_tready drops only
//   once both entries are full, and rises again the cycle after m_tready.
//   Reset (i_rst_n low, synchronous): all columns driven low, entry empty,
//   fail count and warning cleared, passwords back to 1234/2345/3456/4567,
//   output stream empty.
// ---------------------------------------------------------------------------
`default_nettype none

module keypad_scan_code_lock_core
    import kscl_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,

    input  wire                     s_tvalid,
    output logic                    s_tready,
    input  wire  [S_TDATA_W-1:0]    s_tdata,   // [3:0] rows, [7:4] zero
    input  wire                     s_tuser,   // [0] op

    output logic                    m_tvalid,
    input  wire                     m_tready,
    output logic [M_TDATA_W-1:0]    m_tdata,   // [2:0] column_drive, [3] key_entered,
                                               // [7:4] key_digit, [8] clear_pressed,
                                               // [11:9] digits_held, [13:12] verdict,
                                               // [16:14] failed_count, [17] warning_on,
                                               // [23:18] zero

    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [PW_W-1:0]         i_cfg_data
);

    // ---------------- state ----------------
    logic [PW_W-1:0]    r_pw [NUM_DIGITS];
    logic [COL_W-1:0]   r_col,   n_col;
    logic [DIGIT_W-1:0] r_dig [NUM_DIGITS];
    logic [DIGIT_W-1:0] n_dig [NUM_DIGITS];
    logic [COUNT_W-1:0] r_cnt,   n_cnt;
    logic [COUNT_W-1:0] r_fail,  n_fail;
    logic               r_warn,  n_warn;

    // output register and skid
    logic               r_out_valid, r_skid_valid;
    t_result            r_out, r_skid;
    t_result            n_res;

    logic               s_accept, m_pop, cfg_we;
    logic [ROW_W-1:0]   rows;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;
    assign s_tready    = !r_skid_valid;
    assign s_accept    = s_tvalid && s_tready;
    assign m_pop       = r_out_valid && m_tready;
    assign m_tvalid    = r_out_valid;
    assign m_tdata     = {{(M_TDATA_W-RESULT_W){1'b0}}, r_out};
    assign rows        = s_tdata[ROW_W-1:0];

    // ---------------- single-pass decode and compare ----------------
    logic               cl, cm, cr, r1, r2, r3, r4;
    logic               got, star, store, match;
    logic [DIGIT_W-1:0] digit;
    logic [1:0]         sel;
    logic [PW_W-1:0]    pw;

    always_comb begin
        cr = !r_col[0];
        cm = !r_col[1];
        cl = !r_col[2];
        r1 = !rows[0];
        r2 = !rows[1];
        r3 = !rows[2];
        r4 = !rows[3];

        got   = 1'b1;
        star  = 1'b0;
        digit = '0;
        priority if (cl && r4) digit = 4'd1;
        else if (cm && r4)     digit = 4'd2;
        else if (cr && r4)     digit = 4'd3;
        else if (cl && r3)     digit = 4'd4;
        else if (cm && r3)     digit = 4'd5;
        else if (cr && r3)     digit = 4'd6;
        else if (cl && r2)     digit = 4'd7;
        else if (cm && r2)     digit = 4'd8;
        else if (cr && r2)     digit = 4'd9;
        else if (cl && r1) begin
            star = 1'b1;
            got  = 1'b0;
        end
        else if (cm && r1)     digit = 4'd0;
        else                   got   = 1'b0;

        // next column phase for a tick
        priority if (r_col[2] == 1'b0) n_col = COL_RIGHT;
        else if (r_col[0] == 1'b0)     n_col = COL_MIDDLE;
        else if (r_col[1] == 1'b0)     n_col = COL_LEFT;
        else                           n_col = {1'b0, r_col[1:0]};

        n_dig = r_dig;
        n_cnt = r_cnt;
        n_fail = r_fail;
        n_warn = r_warn;
        store = 1'b0;
        match = 1'b0;
        sel = (r_fail < 3'd3) ? r_fail[1:0] : 2'd3;
        pw  = r_pw[sel];

        n_res               = '0;
        n_res.column_drive  = r_col;

        if (s_tuser == OP_TICK) begin
            n_res.column_drive = n_col;
        end else begin
            n_col = r_col;
            if (star) begin
                for (int k = 0; k < NUM_DIGITS; k++) n_dig[k] = EMPTY_DIGIT;
                n_cnt = '0;
            end else if (got && r_cnt < FULL_COUNT) begin
                n_dig[r_cnt[1:0]] = digit;
                n_cnt = r_cnt + 3'd1;
                store = 1'b1;
            end

            n_res.verdict = VERDICT_NONE;
            if (n_cnt >= FULL_COUNT) begin
                match = 1'b1;
                for (int k = 0; k < NUM_DIGITS; k++) begin
                    if (n_dig[k] != pw[PW_W-1-DIGIT_W*k -: DIGIT_W]) match = 1'b0;
                end
                if (match) begin
                    n_fail = '0;
                    n_warn = 1'b0;
                    n_res.verdict = VERDICT_ACCEPT;
                end else begin
                    if (r_fail < MAX_FAILS) n_fail = r_fail + 3'd1;
                    if (n_fail >= MAX_FAILS) n_warn = 1'b1;
                    n_res.verdict = VERDICT_REJECT;
                end
                for (int k = 0; k < NUM_DIGITS; k++) n_dig[k] = EMPTY_DIGIT;
                n_cnt = '0;
            end

            n_res.key_entered   = store;
            n_res.key_digit     = digit;
            n_res.clear_pressed = star;
        end

        n_res.digits_held  = n_cnt;
        n_res.failed_count = n_fail;
        n_res.warning_on   = n_warn;
    end

    // ---------------- lock state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= COL_RESET;
            r_cnt  <= '0;
            r_fail <= '0;
            r_warn <= 1'b0;
            for (int k = 0; k < NUM_DIGITS; k++) r_dig[k] <= EMPTY_DIGIT;
        end else if (s_accept) begin
            r_col  <= n_col;
            r_cnt  <= n_cnt;
            r_fail <= n_fail;
            r_warn <= n_warn;
            r_dig  <= n_dig;
        end
    end

    // ---------------- password registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw[0] <= PW_FIRST_RST;
            r_pw[1] <= PW_SECOND_RST;
            r_pw[2] <= PW_THIRD_RST;
            r_pw[3] <= PW_FOURTH_RST;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                REG_PW_FIRST:  r_pw[0] <= i_cfg_data;
                REG_PW_SECOND: r_pw[1] <= i_cfg_data;
                REG_PW_THIRD:  r_pw[2] <= i_cfg_data;
                REG_PW_FOURTH: r_pw[3] <= i_cfg_data;
                default: ;  // unknown index: dropped
            endcase
        end
    end

    // ---------------- result register + skid ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (m_pop) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (s_accept) begin
            if (!r_out_valid || m_pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (m_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (m_pop) r_out <= r_skid;
        end else if (s_accept) begin
            if (!r_out_valid || m_pop) r_out  <= n_res;
            else                       r_skid <= n_res;
        end
    end

endmodule : keypad_scan_code_lock_core

`default_nettype wire

### bench/keypad_scan_code_lock_core_tb.sv
// ---------------------------------------------------------------------------
// keypad_scan_code_lock_core_tb
// Self-checking bench for the keypad scanner and four-digit code lock.
// A local copy of the scan and lock state predicts every result word. Each
// word seen on the master stream is checked field by field against the oldest
// prediction. Stimulus starts with a directed keypad walk, password and
// lockout cases, and register extremes. It then runs random keying sessions
// under several source and sink idle mixes, with one long sink hold-off.
// ---------------------------------------------------------------------------
module keypad_scan_code_lock_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kscl_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;  // cycles with no handshake at all
    localparam int HOLD_CYCLES  = 60;    // long sink hold-off
    localparam int DRAIN_CYCLES = 3;     // margin after the last predicted word

    // Key codes beyond the ten digits
    localparam logic [DIGIT_W-1:0] KEY_STAR = 4'd10;
    localparam logic [DIGIT_W-1:0] KEY_HASH = 4'd11;

    // Register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOP   = 8'hFF;

    // -----------------------------------------------------------------------
    // DUT ports
    // -----------------------------------------------------------------------
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 s_tuser     = OP_TICK;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [PW_W-1:0]      i_cfg_data  = '0;

    always #(CLK_HALF) i_clk = ~i_clk;

    keypad_scan_code_lock_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // -----------------------------------------------------------------------
    // Predicted lock state (updated when a word is accepted)
    // -----------------------------------------------------------------------
    logic [COL_W-1:0]   scan_cols;
    logic [DIGIT_W-1:0] code_buf [NUM_DIGITS];
    logic [COUNT_W-1:0] code_len;
    logic [COUNT_W-1:0] fail_cnt;
    logic               alarm;
    logic [PW_W-1:0]    pw_bank [NUM_DIGITS];

    t_result pending_results[$];   // predicted words not yet seen
    int      words_sent  = 0;
    int      mismatches  = 0;
    int      src_idle    = 0;      // percent of words preceded by a gap
    int      snk_stall   = 0;      // percent of cycles with m_tready low
    logic    hold_ask    = 1'b0;   // toggled to request a long hold-off
    int      stuck_cycles = 0;

    function automatic void clear_code();
        for (int k = 0; k < NUM_DIGITS; k++)
            code_buf[k] = EMPTY_DIGIT;
        code_len = '0;
    endfunction

    // Advance the predicted state by one input word and return its result.
    function automatic t_result lock_step(input logic op, input logic [ROW_W-1:0] rows);
        t_result            r;
        logic               cl, cm, cr, got, star;
        logic [ROW_W-1:0]   low;
        logic [DIGIT_W-1:0] dig;
        logic [1:0]         sel;
        r    = '0;
        dig  = '0;
        got  = 1'b1;
        star = 1'b0;
        if (op == OP_TICK) begin
            // left -> right -> middle -> left; reset state (all low) goes right,
            // all high pulls the left column low
            if (!scan_cols[2])      scan_cols = COL_RIGHT;
            else if (!scan_cols[0]) scan_cols = COL_MIDDLE;
            else if (!scan_cols[1]) scan_cols = COL_LEFT;
            else                    scan_cols = {1'b0, scan_cols[1:0]};
        end else begin
            cl  = !scan_cols[2];
            cm  = !scan_cols[1];
            cr  = !scan_cols[0];
            low = ~rows;
            // top row first; within a row left, middle, right
            if (cl && low[3])      dig = 4'd1;
            else if (cm && low[3]) dig = 4'd2;
            else if (cr && low[3]) dig = 4'd3;
            else if (cl && low[2]) dig = 4'd4;
            else if (cm && low[2]) dig = 4'd5;
            else if (cr && low[2]) dig = 4'd6;
            else if (cl && low[1]) dig = 4'd7;
            else if (cm && low[1]) dig = 4'd8;
            else if (cr && low[1]) dig = 4'd9;
            else if (cl && low[0]) begin
                star = 1'b1;
                got  = 1'b0;
            end
            else if (cm && low[0]) dig = 4'd0;
            else got = 1'b0;           // hash key or nothing pressed

            if (star) begin
                clear_code();
                r.clear_pressed = 1'b1;
            end else if (got && code_len < FULL_COUNT) begin
                code_buf[code_len[1:0]] = dig;
                code_len = code_len + 3'd1;
                r.key_entered = 1'b1;
            end

            if (code_len >= FULL_COUNT) begin
                sel = (fail_cnt > 3'd3) ? 2'd3 : fail_cnt[1:0];
                if ({code_buf[0], code_buf[1], code_buf[2], code_buf[3]} == pw_bank[sel]) begin
                    fail_cnt  = '0;
                    alarm     = 1'b0;
                    r.verdict = VERDICT_ACCEPT;
                end else begin
                    if (fail_cnt < MAX_FAILS) fail_cnt = fail_cnt + 3'd1;
                    if (fail_cnt >= MAX_FAILS) alarm = 1'b1;
                    r.verdict = VERDICT_REJECT;
                end
                clear_code();
            end
        end
        r.column_drive = scan_cols;
        r.key_digit    = dig;
        r.digits_held  = code_len;
        r.failed_count = fail_cnt;
        r.warning_on   = alarm;
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Source side
    // -----------------------------------------------------------------------
    // Offer one word, wait for the handshake, then record its prediction.
    task automatic send_word(input logic op, input logic [ROW_W-1:0] rows);
        if (src_idle > 0 && $urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W-ROW_W){1'b0}}, rows};
        do @(posedge i_clk); while (!s_tready);
        pending_results.push_back(lock_step(op, rows));
        words_sent++;
    endtask

    // Tick to the key's column, then sample with its row low. Rows below it
    // are random: they rank lower and must not change the decode.
    task automatic press_key(input logic [DIGIT_W-1:0] key);
        logic [COL_W-1:0] want;
        logic [ROW_W-1:0] rows;
        int               row;
        case (key)
            4'd1, 4'd4, 4'd7, KEY_STAR: want = COL_LEFT;
            4'd2, 4'd5, 4'd8, 4'd0:     want = COL_MIDDLE;
            default:                    want = COL_RIGHT;
        endcase
        case (key)
            4'd1, 4'd2, 4'd3: row = 3;
            4'd4, 4'd5, 4'd6: row = 2;
            4'd7, 4'd8, 4'd9: row = 1;
            default:          row = 0;
        endcase
        while (scan_cols != want)
            send_word(OP_TICK, ROW_W'($urandom_range(15)));
        rows = ROW_W'(($urandom_range(15) & ((1 << row) - 1)) | (32'hF << (row + 1)));
        send_word(OP_SAMPLE, rows);
    endtask

    // Key in four digits, first digit from the top nibble. Nibbles above
    // nine cannot be typed, so a random digit stands in for them.
    task automatic enter_code(input logic [PW_W-1:0] code);
        logic [DIGIT_W-1:0] nib;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            nib = code[PW_W-1-DIGIT_W*k -: DIGIT_W];
            if (nib > 4'd9) nib = DIGIT_W'($urandom_range(9));
            press_key(nib);
        end
    endtask

    function automatic logic [PW_W-1:0] active_password();
        return pw_bank[(fail_cnt > 3'd3) ? 2'd3 : fail_cnt[1:0]];
    endfunction

    function automatic logic [PW_W-1:0] random_bcd();
        logic [PW_W-1:0] v;
        for (int k = 0; k < NUM_DIGITS; k++)
            v[DIGIT_W*k +: DIGIT_W] = DIGIT_W'($urandom_range(9));
        return v;
    endfunction

    // Lower valid and wait until every predicted word has come out.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Only called with the block idle. Valid is dropped after each write before the task returns.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PW_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx <= REG_PW_FOURTH) pw_bank[idx[1:0]] = val;
        @(posedge i_clk);
    endtask

    // -----------------------------------------------------------------------
    // Sink side: check each result word, then pick next m_tready
    // -----------------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned exp, input int unsigned act);
        if (exp != act) begin
            $error("%s: expected %0d, got %0d", name, exp, act);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : sink_side
        t_result seen, want;
        logic    hold_seen;
        int      hold_left;
        if (i_rst_n && m_tvalid && m_tready) begin
            seen = m_tdata[RESULT_W-1:0];
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: %h", m_tdata);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("column_drive",  want.column_drive,  seen.column_drive);
                check_field("key_entered",   want.key_entered,   seen.key_entered);
                check_field("key_digit",     want.key_digit,     seen.key_digit);
                check_field("clear_pressed", want.clear_pressed, seen.clear_pressed);
                check_field("digits_held",   want.digits_held,   seen.digits_held);
                check_field("verdict",       want.verdict,       seen.verdict);
                check_field("failed_count",  want.failed_count,  seen.failed_count);
                check_field("warning_on",    want.warning_on,    seen.warning_on);
                check_field("tdata pad", 0, m_tdata[M_TDATA_W-1:RESULT_W]);
            end
        end
        // a toggle of hold_ask starts a long hold-off counted here
        if (hold_seen !== hold_ask) begin
            hold_seen = hold_ask;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_stall);
        end
    end

    // Watchdog: no handshake of any kind for too long ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STALL_LIMIT) begin
            $display("FAIL keypad_scan_code_lock_core");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------
    // Samples with all columns low right after reset exercise the decode
    // priority across columns; then every key position, hash included, once
    // per column phase.
    task automatic test_scan_walk();
        send_word(OP_SAMPLE, 4'hF);    // no key
        send_word(OP_SAMPLE, 4'hE);    // bottom row, left wins: star
        send_word(OP_SAMPLE, 4'h0);    // everything pressed: key 1
        for (int c = 0; c < 3; c++) begin
            send_word(OP_TICK, 4'h0);
            send_word(OP_SAMPLE, 4'hE);
            send_word(OP_SAMPLE, 4'hD);
            send_word(OP_SAMPLE, 4'hB);
            send_word(OP_SAMPLE, 4'h7);
        end
        send_word(OP_TICK, 4'hF);
        press_key(KEY_STAR);
    endtask

    // Default passwords: accept, reject, password chosen by fail count,
    // saturation at four with the warning, and a match clearing both.
    task automatic test_lockout();
        press_key(KEY_HASH);
        enter_code(PW_FIRST_RST);
        enter_code(16'h0000);
        enter_code(PW_SECOND_RST);
        for (int k = 0; k < 5; k++)
            enter_code(16'h9876);
        enter_code(PW_FOURTH_RST);
        // star in the middle of an entry drops the held digits
        press_key(4'd1);
        press_key(4'd2);
        press_key(KEY_STAR);
        enter_code(PW_FIRST_RST);
    endtask

    // Register extremes, a nibble above nine (never matches), and writes to
    // indexes that hold no register.
    task automatic test_password_regs();
        wait_drain();
        write_reg(REG_PW_FIRST,  16'h0000);
        write_reg(REG_PW_SECOND, 16'h9999);
        write_reg(REG_PW_THIRD,  16'h1A23);
        write_reg(REG_PW_FOURTH, 16'h0999);
        write_reg(REG_SPARE,     16'h5555);
        write_reg(REG_TOP,       16'hFFFF);
        enter_code(16'h0000);
        enter_code(16'h1111);
        enter_code(16'h9999);
        enter_code(16'h1111);
        enter_code(16'h1111);
        enter_code(16'h1023);     // third password cannot be typed
        enter_code(16'h0999);
    endtask

    // Sink holds off long enough that the output fills and s_tready drops
    // while the source keeps offering words.
    task automatic test_backpressure();
        src_idle = 0;
        snk_stall <= 0;
        hold_ask <= ~hold_ask;
        for (int k = 0; k < 12; k++)
            press_key(DIGIT_W'($urandom_range(11)));
        wait_drain();
    endtask

    // Mostly well-formed keying sessions with random content, plus stray
    // keys and raw noise words.
    task automatic run_sessions(input int count);
        int              stop;
        int              pick;
        int              pos;
        logic [PW_W-1:0] code;
        stop = words_sent + count;
        while (words_sent < stop) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                enter_code(active_password());
            end else if (pick < 55) begin
                enter_code(random_bcd());
            end else if (pick < 65) begin
                // one digit off from the right password
                code = active_password();
                pos  = $urandom_range(3);
                code[DIGIT_W*pos +: DIGIT_W] =
                    DIGIT_W'((code[DIGIT_W*pos +: DIGIT_W] + $urandom_range(1, 9)) % 10);
                enter_code(code);
            end else if (pick < 75) begin
                repeat ($urandom_range(1, 3)) press_key(DIGIT_W'($urandom_range(9)));
                press_key(KEY_STAR);
            end else if (pick < 82) begin
                press_key(KEY_HASH);
            end else begin
                send_word(1'($urandom_range(1)), ROW_W'($urandom_range(15)));
            end
        end
    endtask

    // One random phase: fresh passwords written while idle, then traffic.
    task automatic test_random_phase(input int gap_pct, input int stall_pct);
        wait_drain();
        for (int k = 0; k < NUM_DIGITS; k++)
            write_reg(CFG_IDX_W'(k), ($urandom_range(3) == 0) ?
                      PW_W'($urandom_range(16'h9999)) : random_bcd());
        src_idle = gap_pct;
        snk_stall <= stall_pct;
        run_sessions(70);
    endtask

    initial begin
        for (int k = 0; k < NUM_DIGITS; k++)
            code_buf[k] = EMPTY_DIGIT;
        scan_cols  = COL_RESET;
        code_len   = '0;
        fail_cnt   = '0;
        alarm      = 1'b0;
        pw_bank[0] = PW_FIRST_RST;
        pw_bank[1] = PW_SECOND_RST;
        pw_bank[2] = PW_THIRD_RST;
        pw_bank[3] = PW_FOURTH_RST;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_scan_walk();
        test_lockout();
        test_password_regs();
        test_backpressure();
        test_random_phase(0, 0);
        test_random_phase(66, 0);
        test_random_phase(0, 66);
        test_random_phase(23, 23);
        wait_drain();

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASS keypad_scan_code_lock_core");
        end else begin
            $display("FAIL keypad_scan_code_lock_core");
        end
        $finish;
    end

endmodule
